FILE: src/blake2b_hash_engine_top_assert.svh
// Assertion macros for the hash engine checker
`ifndef BLAKE2B_HASH_ENGINE_TOP_ASSERT_SVH
`define BLAKE2B_HASH_ENGINE_TOP_ASSERT_SVH

// next-cycle implication, masked while reset is asserted
`define B2B_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hash engine port check failed");

// next-cycle implication, checked during reset as well
`define B2B_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hash engine reset check failed");

`endif

FILE: src/b2b_pkg.sv
`timescale 1ns / 1ps
package b2b_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_MSG   = 2'd2,
        CMD_FIN   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic       we;
        logic       idx;
        logic [6:0] data;
    } t_cfg;

    localparam int Q_DEPTH = 4;
    localparam int ROUNDS = 12;
    localparam logic CFG_DIGEST_LEN = 1'b0;
    localparam logic CFG_KEY_LEN = 1'b1;
    localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

    localparam logic [63:0] IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    // message schedule, rows ten and eleven repeat rows zero and one
    localparam logic [3:0] SIGMA [12][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    function automatic logic [3:0] sigma_at(logic [3:0] rnd, logic [3:0] pos);
        logic [3:0] res;
        res = 4'd0;
        if (rnd < 4'(ROUNDS)) begin
            res = SIGMA[rnd][pos];
        end
        return res;
    endfunction

endpackage

FILE: src/b2b_if.sv
`timescale 1ns / 1ps
interface b2b_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface b2b_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       digest_last;

    modport source (output valid, output digest_byte, output digest_last, input ready);
    modport sink (input valid, input digest_byte, input digest_last, output ready);
endinterface

FILE: src/b2b_front.sv
`timescale 1ns / 1ps
module b2b_front
    import b2b_pkg::*;
#(
    parameter int QDEPTH = Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2b_in_if.sink     i_cmd_if,
    input  logic       i_pop,
    output t_qhead     o_head
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_item          r_q [QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;
    t_item          w_item;

    assign i_cmd_if.ready = (r_cnt != FULL_CNT);
    assign w_push = i_cmd_if.valid && i_cmd_if.ready;
    assign w_pop = i_pop && (r_cnt != '0);

    // classify the command code on the way in
    assign w_item.cmd = t_cmd'(i_cmd_if.command);
    assign w_item.data = i_cmd_if.data_byte;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/b2b_back.sv
`timescale 1ns / 1ps
module b2b_back
    import b2b_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_qhead     i_head,
    output logic       o_pop,
    b2b_out_if.source  o_dig_if
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_HI,
        ST_INIT,
        ST_RUN,
        ST_FOLD,
        ST_EMIT
    } t_state;

    typedef logic [3:0][63:0] t_row;

    function automatic logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_row rot_row(t_row row, logic [1:0] k);
        t_row res;
        logic [1:0] idx;
        for (int j = 0; j < 4; j++) begin
            idx = 2'(j) + k;
            res[j] = row[idx];
        end
        return res;
    endfunction

    // bytes at or above the write limit read as zero padding
    function automatic logic [63:0] mask_word(logic [63:0] d, logic [3:0] w, logic [7:0] lim);
        logic [63:0] res;
        for (int j = 0; j < 8; j++) begin
            res[8*j +: 8] = ({1'b0, w, 3'(j)} < lim) ? d[8*j +: 8] : 8'd0;
        end
        return res;
    endfunction

    t_state         r_state;
    logic [63:0]    r_h [8];
    logic [63:0]    r_cnt_lo;
    logic [63:0]    r_cnt_hi;
    logic           r_carry;
    logic [7:0]     r_fill;
    logic [7:0]     r_lim;
    logic           r_fin;
    logic [7:0]     r_byte;
    logic [6:0]     r_dl;
    logic [6:0]     r_kl;
    logic [3:0]     r_rnd;
    logic [2:0]     r_g;
    logic [1:0]     r_qs;
    t_row           r_va;
    t_row           r_vb;
    t_row           r_vc;
    t_row           r_vd;
    logic [5:0]     r_oidx;
    logic [63:0]    r_mem [16];
    logic [63:0]    r_rd0;
    logic [63:0]    r_rd1;
    logic [3:0]     r_ra0;
    logic [3:0]     r_ra1;

    logic [6:0]     w_kl;
    logic [6:0]     w_dl;
    logic           w_take;
    logic           w_key_ok;
    logic           w_we;
    logic [3:0]     w_wa;
    logic [2:0]     w_wl;
    logic [7:0]     w_wd;
    logic           w_re;
    logic [3:0]     w_rd_rnd;
    logic [2:0]     w_rd_g;
    logic           w_last_g;
    logic [63:0]    w_mx;
    logic [63:0]    w_my;
    logic [63:0]    w_sum_a;
    logic [63:0]    w_sum_c;
    logic [64:0]    w_lo_sum;
    logic [63:0]    w_lo_add;
    logic [1:0]     w_kb;
    logic [1:0]     w_kc;
    logic [1:0]     w_kd;
    t_row           w_va;
    t_row           w_vb;
    t_row           w_vc;
    t_row           w_vd;
    logic [63:0]    w_hword;
    logic           w_olast;

    assign w_kl = (r_kl > 7'd64) ? 7'd64 : r_kl;
    assign w_dl = (r_dl == 7'd0) ? 7'd1 : ((r_dl > 7'd64) ? 7'd64 : r_dl);

    assign o_pop = (r_state == ST_IDLE) && i_head.valid;
    assign w_take = o_pop;
    assign w_key_ok = (w_kl != 7'd0) && (r_cnt_lo == 64'd0) && (r_cnt_hi == 64'd0)
                      && (r_fill < {1'b0, w_kl});

    // byte store into the message buffer
    always_comb begin
        w_we = 1'b0;
        w_wa = r_fill[6:3];
        w_wl = r_fill[2:0];
        w_wd = i_head.item.data;
        if (w_take) begin
            case (i_head.item.cmd)
                CMD_KEY: w_we = w_key_ok;
                CMD_MSG: w_we = !r_fill[7];
                default: w_we = 1'b0;
            endcase
        end else if (r_state == ST_FOLD && !r_fin) begin
            w_we = 1'b1;
            w_wa = 4'd0;
            w_wl = 3'd0;
            w_wd = r_byte;
        end
    end

    assign w_last_g = (r_rnd == 4'(ROUNDS - 1)) && (r_g == 3'd7);

    // fetch the two message words of the next mixing step
    always_comb begin
        w_re = 1'b0;
        w_rd_rnd = 4'd0;
        w_rd_g = 3'd0;
        if (r_state == ST_INIT) begin
            w_re = 1'b1;
        end else if (r_state == ST_RUN && r_qs == 2'd3 && !w_last_g) begin
            w_re = 1'b1;
            w_rd_g = r_g + 3'd1;
            w_rd_rnd = (r_g == 3'd7) ? r_rnd + 4'd1 : r_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa][{w_wl, 3'b000} +: 8] <= w_wd;
        end
        if (w_re) begin
            r_rd0 <= r_mem[sigma_at(w_rd_rnd, {w_rd_g, 1'b0})];
            r_rd1 <= r_mem[sigma_at(w_rd_rnd, {w_rd_g, 1'b1})];
            r_ra0 <= sigma_at(w_rd_rnd, {w_rd_g, 1'b0});
            r_ra1 <= sigma_at(w_rd_rnd, {w_rd_g, 1'b1});
        end
    end

    assign w_mx = mask_word(r_rd0, r_ra0, r_lim);
    assign w_my = mask_word(r_rd1, r_ra1, r_lim);

    assign w_sum_a = r_va[0] + r_vb[0] + (r_qs[1] ? w_my : w_mx);
    assign w_sum_c = r_vc[0] + r_vd[0];

    // row shifts that walk columns, then diagonals, then back
    always_comb begin
        w_kb = 2'd1;
        w_kc = 2'd1;
        w_kd = 2'd1;
        if (r_g == 3'd3) begin
            w_kb = 2'd2;
            w_kc = 2'd3;
            w_kd = 2'd0;
        end else if (r_g == 3'd7) begin
            w_kb = 2'd0;
            w_kc = 2'd3;
            w_kd = 2'd2;
        end
    end

    always_comb begin
        w_va = r_va;
        w_vb = r_vb;
        w_vc = r_vc;
        w_vd = r_vd;
        case (r_qs)
            2'd0: begin
                w_va[0] = w_sum_a;
                w_vd[0] = rotr(r_vd[0] ^ w_sum_a, 32);
            end
            2'd1: begin
                w_vc[0] = w_sum_c;
                w_vb[0] = rotr(r_vb[0] ^ w_sum_c, 24);
            end
            2'd2: begin
                w_va[0] = w_sum_a;
                w_vd[0] = rotr(r_vd[0] ^ w_sum_a, 16);
            end
            default: begin
                w_vc[0] = w_sum_c;
                w_vb[0] = rotr(r_vb[0] ^ w_sum_c, 63);
                w_va = rot_row(w_va, 2'd1);
                w_vb = rot_row(w_vb, w_kb);
                w_vc = rot_row(w_vc, w_kc);
                w_vd = rot_row(w_vd, w_kd);
            end
        endcase
    end

    assign w_lo_add = (i_head.item.cmd == CMD_FIN) ? {56'd0, r_fill} : 64'd128;
    assign w_lo_sum = {1'b0, r_cnt_lo} + {1'b0, w_lo_add};

    assign w_hword = r_h[r_oidx[5:3]];
    assign w_olast = ({1'b0, r_oidx} + 7'd1) == w_dl;

    assign o_dig_if.valid = (r_state == ST_EMIT);
    assign o_dig_if.digest_byte = w_hword[{r_oidx[2:0], 3'b000} +: 8];
    assign o_dig_if.digest_last = w_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= IV[i];
            end
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            r_carry <= 1'b0;
            r_fill <= '0;
            r_lim <= '0;
            r_fin <= 1'b0;
            r_dl <= 7'd64;
            r_kl <= 7'd0;
            r_rnd <= '0;
            r_g <= '0;
            r_qs <= '0;
            r_oidx <= '0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_DIGEST_LEN: r_dl <= i_cfg.data;
                    CFG_KEY_LEN: r_kl <= i_cfg.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        unique case (i_head.item.cmd)
                            CMD_START: begin
                                for (int i = 1; i < 8; i++) begin
                                    r_h[i] <= IV[i];
                                end
                                r_h[0] <= IV[0] ^ PARAM_BASE ^ {49'd0, w_kl, 8'd0}
                                          ^ {57'd0, w_dl};
                                r_cnt_lo <= '0;
                                r_cnt_hi <= '0;
                                r_fill <= '0;
                                r_lim <= '0;
                            end
                            CMD_KEY: begin
                                if (w_key_ok) begin
                                    r_lim <= r_fill + 8'd1;
                                    r_fill <= ((r_fill + 8'd1) == {1'b0, w_kl}) ? 8'd128
                                              : r_fill + 8'd1;
                                end
                            end
                            CMD_MSG: begin
                                if (r_fill[7]) begin
                                    r_cnt_lo <= w_lo_sum[63:0];
                                    r_carry <= w_lo_sum[64];
                                    r_fin <= 1'b0;
                                    r_byte <= i_head.item.data;
                                    r_state <= ST_CNT_HI;
                                end else begin
                                    r_fill <= r_fill + 8'd1;
                                    r_lim <= r_fill + 8'd1;
                                end
                            end
                            CMD_FIN: begin
                                r_cnt_lo <= w_lo_sum[63:0];
                                r_carry <= w_lo_sum[64];
                                r_fin <= 1'b1;
                                r_state <= ST_CNT_HI;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CNT_HI: begin
                    r_cnt_hi <= r_cnt_hi + {63'd0, r_carry};
                    r_state <= ST_INIT;
                end
                ST_INIT: begin
                    for (int j = 0; j < 4; j++) begin
                        r_va[j] <= r_h[j];
                        r_vb[j] <= r_h[j + 4];
                        r_vc[j] <= IV[j];
                    end
                    r_vd[0] <= IV[4] ^ r_cnt_lo;
                    r_vd[1] <= IV[5] ^ r_cnt_hi;
                    r_vd[2] <= r_fin ? ~IV[6] : IV[6];
                    r_vd[3] <= IV[7];
                    r_rnd <= '0;
                    r_g <= '0;
                    r_qs <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_va <= w_va;
                    r_vb <= w_vb;
                    r_vc <= w_vc;
                    r_vd <= w_vd;
                    r_qs <= r_qs + 2'd1;
                    if (r_qs == 2'd3) begin
                        if (w_last_g) begin
                            r_state <= ST_FOLD;
                        end else begin
                            r_g <= w_rd_g;
                            r_rnd <= w_rd_rnd;
                        end
                    end
                end
                ST_FOLD: begin
                    for (int j = 0; j < 4; j++) begin
                        r_h[j] <= r_h[j] ^ r_va[j] ^ r_vc[j];
                        r_h[j + 4] <= r_h[j + 4] ^ r_vb[j] ^ r_vd[j];
                    end
                    if (r_fin) begin
                        r_fill <= 8'd128;
                        r_oidx <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        // the pending message byte opens the next block
                        r_fill <= 8'd1;
                        r_lim <= 8'd1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (o_dig_if.ready) begin
                        if (w_olast) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 6'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: src/blake2b_hash_engine_top.sv
`timescale 1ns / 1ps
// Channel    Dir  Fields                      Word
// i_cmd_if   in   command[1:0], data_byte[7:0] one command (start, key, message, finish)
// o_dig_if   out  digest_byte[7:0], digest_last one digest byte, last flag on the final one
//
// Key, message and start words are taken straight from the queue head while the core is idle.
// A compression (block change or finish) runs one mixing quarter-step per cycle over
// 12 rounds of 8 mixes, after count and load steps and before a fold step.
// Finish then presents digest_len bytes, clamped to 1 to 64, one per cycle while o_dig_if.ready is high.
// The command queue keeps taking words until full while a compression runs or a digest stalls.
// Reset is synchronous active low and needs no clearing pass.
module blake2b_hash_engine_top
    import b2b_pkg::*;
#(
    parameter int QDEPTH = Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b2b_in_if.sink     i_cmd_if,
    b2b_out_if.source  o_dig_if,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    t_qhead w_head;
    logic   w_pop;
    t_cfg   w_cfg;

    assign w_cfg.we = i_cfg_we;
    assign w_cfg.idx = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    b2b_front #(
        .QDEPTH (QDEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (i_cmd_if),
        .i_pop    (w_pop),
        .o_head   (w_head)
    );

    b2b_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_dig_if (o_dig_if)
    );

endmodule

FILE: src/b2b_checker.sv
`timescale 1ns / 1ps
`include "blake2b_hash_engine_top_assert.svh"
module b2b_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // a stalled digest byte holds
    `B2B_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
    // digest bytes run without gaps until the last one
    `B2B_ASSERT_NEXT(a_burst_cont, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid)
    // the last byte closes the burst
    `B2B_ASSERT_NEXT(a_burst_end, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_last, !i_out_valid)
    // no digest right out of reset
    `B2B_ASSERT_NEXT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind blake2b_hash_engine_top b2b_checker u_b2b_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_dig_if.valid),
    .i_out_ready (o_dig_if.ready),
    .i_out_byte  (o_dig_if.digest_byte),
    .i_out_last  (o_dig_if.digest_last)
);

FILE: verif/blake2b_hash_engine_top_test.sv
`timescale 1ns / 1ps
module blake2b_hash_engine_top_test;
    import b2b_pkg::*;

    localparam int DRAIN_CYCLES = 1200;
    localparam int RANDOM_ITEMS = 140;
    localparam int PLAN_LEN = 24;

    // row: {config write, register, value, command, data}
    localparam logic [18:0] PLAN [PLAN_LEN] = '{
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'h00},      // finish straight out of reset
        {1'b0, 1'b0, 7'd0, CMD_KEY, 8'hAA},      // key byte while unkeyed: dropped
        {1'b0, 1'b0, 7'd0, CMD_START, 8'hFF},
        {1'b0, 1'b0, 7'd0, CMD_MSG, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_MSG, 8'hFF},
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_MSG, 8'h5A},      // message after finish: compress full block
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'hFF},
        {1'b1, CFG_DIGEST_LEN, 7'd0, CMD_START, 8'h00},
        {1'b1, CFG_KEY_LEN, 7'd2, CMD_START, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_START, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_KEY, 8'h01},
        {1'b0, 1'b0, 7'd0, CMD_KEY, 8'hFE},
        {1'b0, 1'b0, 7'd0, CMD_KEY, 8'h80},      // one key byte too many: dropped
        {1'b0, 1'b0, 7'd0, CMD_MSG, 8'h33},
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'h00},
        {1'b1, CFG_DIGEST_LEN, 7'd127, CMD_START, 8'h00},
        {1'b1, CFG_KEY_LEN, 7'd0, CMD_START, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_START, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'h00},
        {1'b1, CFG_DIGEST_LEN, 7'd64, CMD_START, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_START, 8'h00},
        {1'b0, 1'b0, 7'd0, CMD_FIN, 8'h00}
    };

    localparam logic [63:0] INIT_WORDS [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam int SCHED [10][16] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
        '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
        '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
        '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
        '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
        '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
        '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
        '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
        '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [6:0] i_cfg_data;

    b2b_in_if cmd_if ();
    b2b_out_if dig_if ();

    blake2b_hash_engine_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_if   (cmd_if),
        .o_dig_if   (dig_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // hash state mirror
    logic [63:0] chain [8];
    logic [7:0] blk [128];
    logic [63:0] cnt_lo;
    logic [63:0] cnt_hi;
    int unsigned fill;
    logic [6:0] dlen_reg;
    logic [6:0] klen_reg;

    logic [8:0] digest_q [$];
    int errors;
    int sent;
    logic steady;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void compress_block(bit last_blk);
        logic [63:0] m [16];
        logic [63:0] v [16];
        int a [8];
        int b [8];
        int c [8];
        int d [8];
        int r;
        int g;
        a = '{0, 1, 2, 3, 0, 1, 2, 3};
        b = '{4, 5, 6, 7, 5, 6, 7, 4};
        c = '{8, 9, 10, 11, 10, 11, 8, 9};
        d = '{12, 13, 14, 15, 15, 12, 13, 14};
        for (int i = 0; i < 16; i++) begin
            m[i] = 64'd0;
            for (int j = 0; j < 8; j++) begin
                m[i] = m[i] | (64'(blk[i * 8 + j]) << (8 * j));
            end
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = chain[i];
            v[i + 8] = INIT_WORDS[i];
        end
        v[12] = v[12] ^ cnt_lo;
        v[13] = v[13] ^ cnt_hi;
        if (last_blk) begin
            v[14] = ~v[14];
        end
        for (r = 0; r < 12; r++) begin
            for (g = 0; g < 8; g++) begin
                v[a[g]] = v[a[g]] + v[b[g]] + m[SCHED[r % 10][2 * g]];
                v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 32);
                v[c[g]] = v[c[g]] + v[d[g]];
                v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 24);
                v[a[g]] = v[a[g]] + v[b[g]] + m[SCHED[r % 10][2 * g + 1]];
                v[d[g]] = rotr(v[d[g]] ^ v[a[g]], 16);
                v[c[g]] = v[c[g]] + v[d[g]];
                v[b[g]] = rotr(v[b[g]] ^ v[c[g]], 63);
            end
        end
        for (int i = 0; i < 8; i++) begin
            chain[i] = chain[i] ^ v[i] ^ v[i + 8];
        end
    endfunction

    function automatic void bump_count(logic [63:0] n);
        cnt_lo = cnt_lo + n;
        if (cnt_lo < n) begin
            cnt_hi = cnt_hi + 64'd1;
        end
    endfunction

    // advance the mirror by one command word, queue any digest bytes
    function automatic void hash_step(t_cmd cmd, logic [7:0] data);
        int unsigned kl;
        int unsigned dl;
        kl = (klen_reg > 7'd64) ? 64 : klen_reg;
        dl = (dlen_reg == 7'd0) ? 1 : ((dlen_reg > 7'd64) ? 64 : dlen_reg);
        case (cmd)
            CMD_START: begin
                for (int i = 0; i < 8; i++) begin
                    chain[i] = INIT_WORDS[i];
                end
                chain[0] = chain[0] ^ 64'h0101_0000 ^ (64'(kl) << 8) ^ 64'(dl);
                for (int i = 0; i < 128; i++) begin
                    blk[i] = 8'd0;
                end
                cnt_lo = 64'd0;
                cnt_hi = 64'd0;
                fill = 0;
            end
            CMD_KEY: begin
                if (kl > 0 && cnt_lo == 64'd0 && cnt_hi == 64'd0 && fill < kl) begin
                    blk[fill % 128] = data;
                    fill++;
                    if (fill == kl) begin
                        fill = 128;
                    end
                end
            end
            CMD_MSG: begin
                if (fill >= 128) begin
                    bump_count(64'd128);
                    compress_block(1'b0);
                    fill = 0;
                end
                blk[fill % 128] = data;
                fill++;
            end
            default: begin
                bump_count(64'(fill));
                for (int i = fill; i < 128; i++) begin
                    blk[i] = 8'd0;
                end
                compress_block(1'b1);
                fill = 128;
                for (int i = 0; i < dl; i++) begin
                    digest_q.push_back({8'(chain[i / 8] >> (8 * (i % 8))), i + 1 == dl});
                end
            end
        endcase
    endfunction

    task automatic send_word(t_cmd cmd, logic [7:0] data);
        while (!steady && $urandom_range(99) < 38) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.data_byte <= data;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        hash_step(cmd, data);
        sent++;
        steady = (sent >= 80 && sent < 130);
    endtask

    // drop valid, wait for every digest byte and for any compression still running
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_DIGEST_LEN) begin
            dlen_reg = val;
        end else begin
            klen_reg = val;
        end
    endtask

    always @(posedge i_clk) begin
        dig_if.ready <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            if (digest_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected digest word byte=%02h last=%0b",
                             dig_if.digest_byte, dig_if.digest_last);
                end
            end else begin
                if ({dig_if.digest_byte, dig_if.digest_last} !== digest_q[0]) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("digest mismatch: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                                 digest_q[0][8:1], digest_q[0][0],
                                 dig_if.digest_byte, dig_if.digest_last);
                    end
                end
                void'(digest_q.pop_front());
            end
        end
    end

    initial begin
        logic [18:0] row;
        int unsigned kl;
        int unsigned nmsg;
        int unsigned kcount;
        bit first_long;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = 7'd0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_START;
        cmd_if.data_byte = 8'd0;
        dig_if.ready = 1'b0;
        errors = 0;
        sent = 0;
        steady = 1'b0;
        first_long = 1'b1;
        for (int i = 0; i < 8; i++) begin
            chain[i] = INIT_WORDS[i];
        end
        for (int i = 0; i < 128; i++) begin
            blk[i] = 8'd0;
        end
        cnt_lo = 64'd0;
        cnt_hi = 64'd0;
        fill = 0;
        dlen_reg = 7'd64;
        klen_reg = 7'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PLAN_LEN; p++) begin
            row = PLAN[p];
            if (row[18]) begin
                if (p == 0 || !PLAN[p - 1][18]) begin
                    drain();
                end
                write_reg(row[17], row[16:10]);
            end else begin
                send_word(t_cmd'(row[9:8]), row[7:0]);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(1) == 0) begin
                drain();
                case ($urandom_range(9))
                    0: write_reg(CFG_DIGEST_LEN, 7'd0);
                    1: write_reg(CFG_DIGEST_LEN, 7'($urandom_range(127, 65)));
                    2: write_reg(CFG_DIGEST_LEN, 7'd64);
                    default: write_reg(CFG_DIGEST_LEN, 7'($urandom_range(32, 1)));
                endcase
                case ($urandom_range(9))
                    0: write_reg(CFG_KEY_LEN, 7'($urandom_range(127, 64)));
                    1, 2, 3, 4: write_reg(CFG_KEY_LEN, 7'd0);
                    default: write_reg(CFG_KEY_LEN, 7'($urandom_range(8, 1)));
                endcase
            end
            if ($urandom_range(99) < 15) begin
                // noise: loose commands with random bytes
                repeat ($urandom_range(4, 1)) begin
                    send_word(t_cmd'($urandom_range(3)), 8'($urandom));
                end
            end else begin
                kl = (klen_reg > 7'd64) ? 64 : klen_reg;
                kcount = kl;
                if (kl > 0 && $urandom_range(9) == 0) begin
                    kcount = kl + 1;
                end else if (kl > 1 && $urandom_range(9) == 0) begin
                    kcount = kl - 1;
                end
                if (first_long) begin
                    nmsg = $urandom_range(140, 130);
                    first_long = 1'b0;
                end else begin
                    nmsg = $urandom_range(20);
                end
                send_word(CMD_START, 8'($urandom));
                repeat (kcount) send_word(CMD_KEY, 8'($urandom));
                repeat (nmsg) send_word(CMD_MSG, 8'($urandom));
                send_word(CMD_FIN, 8'($urandom));
                if ($urandom_range(4) == 0) begin
                    send_word(CMD_MSG, 8'($urandom));
                    send_word(CMD_FIN, 8'($urandom));
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
